/* hw/rtl/dilate_3x3_cross_top_assert.svh */
// Assertion macros for the 3x3 cross dilation block.
// Used by dilate_3x3_cross_top; expects signals clk and rst in scope.
`ifndef DILATE_3X3_CROSS_TOP_ASSERT_SVH
`define DILATE_3X3_CROSS_TOP_ASSERT_SVH

// Condition holds in the same cycle as the trigger
`define DIL3X3_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Condition holds in the cycle after the trigger
`define DIL3X3_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hw/rtl/dil3x3_pkg.sv */
// Shared types and constants for the 3x3 cross dilation block.
// No dependencies; used by the interfaces and the top level.
package dil3x3_pkg;

  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W    = 12;
  localparam int DATA_W   = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE   = 3;

  typedef logic [PIX_W-1:0]    pix_t;
  typedef logic [WIDTH_W-1:0]  width_t;
  typedef logic [HEIGHT_W-1:0] height_t;
  typedef logic [ROW_W-1:0]    row_t;
  typedef logic [DATA_W-1:0]   cfg_data_t;
  typedef logic                reg_idx_t;

  // Register indexes
  localparam reg_idx_t REG_IMAGE_WIDTH  = 1'b0;
  localparam reg_idx_t REG_IMAGE_HEIGHT = 1'b1;

  // Request types
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam width_t  WIDTH_RESET  = 11'd640;
  localparam height_t HEIGHT_RESET = 13'd480;

  // Per-item control carried from the accept stage to the compute stage
  typedef struct packed {
    logic emit;   // item produces a result word
    logic zero;   // result forced to zero (border or flush)
    logic last;   // final word of the frame
    logic wr;     // item updates the line stores
  } ctl_t;

  function automatic pix_t pix_max(input pix_t a, input pix_t b);
    pix_max = (a > b) ? a : b;
  endfunction

endpackage

/* hw/rtl/dil3x3_pix_in_if.sv */
// Input pixel channel: valid/ready handshake with request type and pixel.
// Depends on dil3x3_pkg.
interface dil3x3_pix_in_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  dil3x3_pkg::pix_t  pixel_in;

  modport source (output valid, output req_type, output pixel_in, input ready);
  modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

/* hw/rtl/dil3x3_pix_out_if.sv */
// Output pixel channel: valid/ready handshake with dilated pixel and frame end.
// Depends on dil3x3_pkg.
interface dil3x3_pix_out_if;
  logic              valid;
  logic              ready;
  dil3x3_pkg::pix_t  pixel_out;
  logic              frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

/* hw/rtl/dil3x3_cfg_if.sv */
// Configuration write channel: valid/ready with register index and data.
// Depends on dil3x3_pkg.
interface dil3x3_cfg_if;
  logic                   valid;
  logic                   ready;
  dil3x3_pkg::reg_idx_t   reg_index;
  dil3x3_pkg::cfg_data_t  wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

/* hw/rtl/dil3x3_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module dil3x3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered reads, held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

/* hw/rtl/dilate_3x3_cross_top.sv */
// Channel    | Dir | Payload                        | Word accepted when
// pix_in     | in  | req_type, pixel_in             | valid & ready
// pix_out    | out | pixel_out, frame_last          | valid & ready
// cfg        | in  | reg_index, wr_data             | valid & ready (ready always 1)
//
// One word per cycle while pix_out is not stalled; an accepted word is registered in the compute
// stage (line-store read on the accepting edge), then its max-tree result goes to the output register.
// rst resets sizes; clears counters, drain flag, pipeline valids, left pixel; line stores are not cleared.
// A stalled output holds its word; the compute stage keeps its item and the
// line-store read data until it can move, and pix_in.ready drops only then.
// Depends on dil3x3_pkg, the three channel interfaces and dil3x3_ram.
`include "dilate_3x3_cross_top_assert.svh"

module dilate_3x3_cross_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  dil3x3_pix_in_if.sink           pix_in,
  dil3x3_pix_out_if.source        pix_out,
  dil3x3_cfg_if.sink              cfg
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > dil3x3_pkg::WIDTH_W) ? CW + 1 : dil3x3_pkg::WIDTH_W;
  localparam logic [WW-1:0] MAX_W_V   = WW'(MAX_WIDTH);
  localparam logic [WW-1:0] MIN_W_V   = WW'(dil3x3_pkg::MIN_SIZE);
  localparam logic [CW-1:0] LAST_ADDR = CW'(MAX_WIDTH - 1);
  localparam dil3x3_pkg::height_t MAX_H_V =
    dil3x3_pkg::HEIGHT_W'(dil3x3_pkg::MAX_HEIGHT);
  localparam dil3x3_pkg::height_t MIN_H_V =
    dil3x3_pkg::HEIGHT_W'(dil3x3_pkg::MIN_SIZE);

  // Configuration registers
  dil3x3_pkg::width_t  image_width;
  dil3x3_pkg::height_t image_height;

  // Frame position state
  logic [CW-1:0]    col_cnt;
  dil3x3_pkg::row_t row_cnt;
  logic [CW-1:0]    flush_cnt;
  logic             draining;

  // Compute stage
  logic             s1_valid;
  dil3x3_pkg::ctl_t s1_ctl;
  dil3x3_pkg::pix_t s1_px;
  logic [CW-1:0]    s1_col;
  dil3x3_pkg::pix_t left_px;

  // Output register
  logic             out_valid;
  dil3x3_pkg::pix_t out_pixel;
  logic             out_last;

  // Line-store read data
  dil3x3_pkg::pix_t up_rd;
  dil3x3_pkg::pix_t mid_rd;
  dil3x3_pkg::pix_t right_rd;

  logic                 in_accept;
  logic                 s1_adv;
  logic [WW-1:0]        w_eff;
  logic [WW-1:0]        w_last;
  dil3x3_pkg::height_t  h_eff;
  dil3x3_pkg::height_t  h_dec;
  dil3x3_pkg::row_t     h_last;
  logic                 row_end;
  logic                 flush_last;
  logic                 is_flush;
  dil3x3_pkg::ctl_t     ctl_next;
  logic [CW-1:0]        right_addr;
  dil3x3_pkg::pix_t     result;

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= dil3x3_pkg::WIDTH_RESET;
      image_height <= dil3x3_pkg::HEIGHT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        dil3x3_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.wr_data[dil3x3_pkg::WIDTH_W-1:0];
        dil3x3_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.wr_data;
        default: ;
      endcase
    end
  end

  // Frame size, saturated to the supported range
  always_comb begin
    if (WW'(image_width) < MIN_W_V)       w_eff = MIN_W_V;
    else if (WW'(image_width) > MAX_W_V)  w_eff = MAX_W_V;
    else                                  w_eff = WW'(image_width);
    w_last = w_eff - WW'(1);

    if (image_height < MIN_H_V)       h_eff = MIN_H_V;
    else if (image_height > MAX_H_V)  h_eff = MAX_H_V;
    else                              h_eff = image_height;
    h_dec  = h_eff - dil3x3_pkg::HEIGHT_W'(1);
    h_last = h_dec[dil3x3_pkg::ROW_W-1:0];
  end

  // Handshake: compute stage moves on unless its result word is blocked
  assign s1_adv       = s1_valid && (!s1_ctl.emit || !out_valid || pix_out.ready);
  assign pix_in.ready = !s1_valid || s1_adv;
  assign in_accept    = pix_in.valid && pix_in.ready;

  // Classify the incoming word
  assign is_flush   = (pix_in.req_type == dil3x3_pkg::REQ_FLUSH);
  assign row_end    = WW'(col_cnt) >= w_last;
  assign flush_last = WW'(flush_cnt) >= w_last;

  always_comb begin
    if (is_flush) begin
      ctl_next.emit = draining;
      ctl_next.zero = 1'b1;
      ctl_next.last = draining && flush_last;
      ctl_next.wr   = 1'b0;
    end else begin
      ctl_next.emit = !draining && (row_cnt != '0);
      ctl_next.zero = (row_cnt == dil3x3_pkg::ROW_W'(1)) || (col_cnt == '0) || row_end;
      ctl_next.last = 1'b0;
      ctl_next.wr   = !draining;
    end
  end

  // Column, row and flush counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      row_cnt   <= '0;
      flush_cnt <= '0;
      draining  <= 1'b0;
    end else if (in_accept) begin
      if (is_flush) begin
        if (draining) begin
          if (flush_last) begin
            flush_cnt <= '0;
            draining  <= 1'b0;
            col_cnt   <= '0;
            row_cnt   <= '0;
          end else begin
            flush_cnt <= flush_cnt + CW'(1);
          end
        end
      end else if (!draining) begin
        if (row_end) begin
          col_cnt <= '0;
          if (row_cnt >= h_last) begin
            draining  <= 1'b1;
            flush_cnt <= '0;
          end else begin
            row_cnt <= row_cnt + dil3x3_pkg::ROW_W'(1);
          end
        end else begin
          col_cnt <= col_cnt + CW'(1);
        end
      end
    end
  end

  // Line stores: rows r-2 and r-1, read on accept, written as the item leaves
  assign right_addr = (col_cnt == LAST_ADDR) ? '0 : col_cnt + CW'(1);

  dil3x3_ram #(
    .WIDTH (dil3x3_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_older_row (
    .clk       (clk),
    .wr_en     (s1_adv && s1_ctl.wr),
    .wr_addr   (s1_col),
    .wr_data   (mid_rd),
    .rd_en     (in_accept),
    .rd_addr_a (col_cnt),
    .rd_addr_b (col_cnt),
    .rd_data_a (up_rd),
    .rd_data_b ()
  );

  dil3x3_ram #(
    .WIDTH (dil3x3_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_prior_row (
    .clk       (clk),
    .wr_en     (s1_adv && s1_ctl.wr),
    .wr_addr   (s1_col),
    .wr_data   (s1_px),
    .rd_en     (in_accept),
    .rd_addr_a (col_cnt),
    .rd_addr_b (right_addr),
    .rd_data_a (mid_rd),
    .rd_data_b (right_rd)
  );

  // Compute stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ctl <= ctl_next;
      s1_px  <= pix_in.pixel_in;
      s1_col <= col_cnt;
    end
  end

  // Left neighbor: centre-row pixel of the previous column
  always_ff @(posedge clk) begin
    if (rst) begin
      left_px <= '0;
    end else if (s1_adv && s1_ctl.wr) begin
      left_px <= mid_rd;
    end
  end

  // Cross maximum, zero on borders and flush words
  always_comb begin
    if (s1_ctl.zero) begin
      result = '0;
    end else begin
      result = dil3x3_pkg::pix_max(
                 dil3x3_pkg::pix_max(dil3x3_pkg::pix_max(up_rd, mid_rd),
                                     dil3x3_pkg::pix_max(left_px, right_rd)),
                 s1_px);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_ctl.emit) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctl.emit) begin
      out_pixel <= result;
      out_last  <= s1_ctl.last;
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.pixel_out  = out_pixel;
  assign pix_out.frame_last = out_last;

  // Checks
  `DIL3X3_ASSERT_NOW(a_last_is_zero, out_valid && out_last, out_pixel == '0,
    "frame end word carries a nonzero pixel")
  `DIL3X3_ASSERT_NOW(a_drain_col_zero, draining, col_cnt == '0,
    "column count not cleared while draining")
  `DIL3X3_ASSERT_NOW(a_flush_only_draining, !draining, flush_cnt == '0,
    "flush count running outside drain")
  `DIL3X3_ASSERT_NEXT(a_emit_reaches_out, s1_adv && s1_ctl.emit, out_valid,
    "result word lost between compute stage and output")

endmodule

/* test/dilate_3x3_cross_top_tb.sv */
// Self-checking testbench for dilate_3x3_cross_top: directed table, then random frames.
// Depends on dil3x3_pkg, the three channel interfaces and the top level with its RAMs.
`timescale 1ns / 1ps

module dilate_3x3_cross_top_tb;

  localparam int MAX_WIDTH        = 1024;
  localparam int COL_W            = $clog2(MAX_WIDTH);
  localparam int DIR_N            = 16;
  localparam int ITEMS_PER_PHASE  = 350;
  localparam int SETTLE_CYCLES    = 4;
  localparam int END_CYCLES       = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT      = 1000000;

  typedef struct packed {
    dil3x3_pkg::pix_t pix;
    logic             last;
  } dil_word_t;

  typedef enum logic {STEP_CFG, STEP_WORD} step_kind_e;

  // One row of the directed table: register write or input word
  typedef struct {
    step_kind_e            kind;
    logic                  sel;       // register index or request type
    dil3x3_pkg::cfg_data_t data;      // register value or pixel
    logic                  known;     // expected word given in the row
    dil3x3_pkg::pix_t      exp_pix;
    logic                  exp_last;
  } dir_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dil3x3_pix_in_if  pix_in_bus ();
  dil3x3_pix_out_if pix_out_bus ();
  dil3x3_cfg_if     cfg_bus ();

  dilate_3x3_cross_top #(
    .MAX_WIDTH(MAX_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .pix_in(pix_in_bus),
    .pix_out(pix_out_bus),
    .cfg(cfg_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow state of the dilation
  dil3x3_pkg::pix_t    older_row [MAX_WIDTH];
  dil3x3_pkg::pix_t    prior_row [MAX_WIDTH];
  int unsigned         col_cnt = 0;
  int unsigned         row_cnt = 0;
  int unsigned         flush_cnt = 0;
  dil3x3_pkg::pix_t    left_pix = '0;
  bit                  draining = 1'b0;
  bit                  frame_closed = 1'b0;
  dil3x3_pkg::width_t  cfg_width = dil3x3_pkg::WIDTH_RESET;
  dil3x3_pkg::height_t cfg_height = dil3x3_pkg::HEIGHT_RESET;

  dil_word_t   dilated_q [$];
  dil_word_t   want;
  int unsigned error_count = 0;
  int unsigned items_done = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_go = 1'b0;
  bit          long_hold = 1'b0;
  int unsigned cycle_count = 0;
  dir_step_t   dir_tab [DIR_N];

  function automatic int unsigned eff_width();
    int unsigned wv;
    wv = 32'(cfg_width);
    if (wv < dil3x3_pkg::MIN_SIZE) return dil3x3_pkg::MIN_SIZE;
    if (wv > MAX_WIDTH) return MAX_WIDTH;
    return wv;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned hv;
    hv = 32'(cfg_height);
    if (hv < dil3x3_pkg::MIN_SIZE) return dil3x3_pkg::MIN_SIZE;
    if (hv > dil3x3_pkg::MAX_HEIGHT) return dil3x3_pkg::MAX_HEIGHT;
    return hv;
  endfunction

  function automatic dil3x3_pkg::pix_t brighter(input dil3x3_pkg::pix_t a,
                                                input dil3x3_pkg::pix_t b);
    return (a > b) ? a : b;
  endfunction

  // Advance the shadow state by one accepted word; emit tells if a result follows
  function automatic void dilate_step(input logic rt, input dil3x3_pkg::pix_t px,
                                      output logic emit, output dil_word_t word);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    logic [COL_W-1:0] ci;
    logic             row_end;
    dil3x3_pkg::pix_t up;
    dil3x3_pkg::pix_t mid;
    dil3x3_pkg::pix_t right;
    w = eff_width();
    h = eff_height();
    emit = 1'b0;
    word = '0;
    if (rt == dil3x3_pkg::REQ_FLUSH) begin
      // flush only counts while the bottom row is pending
      if (draining) begin
        emit = 1'b1;
        word.last = (flush_cnt >= w - 1);
        if (word.last) begin
          flush_cnt = 0;
          draining = 1'b0;
          col_cnt = 0;
          row_cnt = 0;
          frame_closed = 1'b1;
        end else begin
          flush_cnt++;
        end
      end
    end else if (!draining) begin
      c = col_cnt;
      row_end = (c >= w - 1);
      if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
      ci = COL_W'(c);
      up = older_row[ci];
      mid = prior_row[ci];
      right = (!row_end && c + 1 < MAX_WIDTH) ? prior_row[COL_W'(c + 1)] : '0;
      if (row_cnt > 0) begin
        emit = 1'b1;
        // top row and side columns are zero
        if (row_cnt == 1 || c == 0 || row_end) word.pix = '0;
        else word.pix = brighter(brighter(brighter(up, mid), brighter(left_pix, right)), px);
      end
      older_row[ci] = mid;
      prior_row[ci] = px;
      left_pix = mid;
      if (row_end) begin
        col_cnt = 0;
        if (row_cnt >= h - 1) begin
          draining = 1'b1;
          flush_cnt = 0;
        end else begin
          row_cnt++;
        end
      end else begin
        col_cnt = c + 1;
      end
    end
  endfunction

  function automatic dil3x3_pkg::pix_t rand_pix();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return dil3x3_pkg::pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one input word after a random gap; predict on acceptance
  task automatic send_word(input logic rt, input dil3x3_pkg::pix_t px, input logic known,
                           input dil_word_t known_word);
    logic      emit;
    dil_word_t word;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      pix_in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    pix_in_bus.valid    <= 1'b1;
    pix_in_bus.req_type <= rt;
    pix_in_bus.pixel_in <= px;
    do @(posedge clk); while (!pix_in_bus.ready);
    if ((rt == dil3x3_pkg::REQ_FLUSH) ? draining : !draining) items_done++;
    dilate_step(rt, px, emit, word);
    if (known) begin
      emit = 1'b1;
      word = known_word;
    end
    if (emit) dilated_q.push_back(word);
  endtask

  // Stop offering, wait for all results, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    pix_in_bus.valid <= 1'b0;
    while (dilated_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input dil3x3_pkg::reg_idx_t idx,
                           input dil3x3_pkg::cfg_data_t data);
    @(negedge clk);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wr_data   <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == dil3x3_pkg::REG_IMAGE_WIDTH) cfg_width = data[dil3x3_pkg::WIDTH_W-1:0];
    else cfg_height = data;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // One frame, built from the shadow state so that size changes keep it well formed
  task automatic run_frame(input dil3x3_pkg::cfg_data_t wv, input dil3x3_pkg::cfg_data_t hv,
                           input bit mid_ok);
    int unsigned pix_sent;
    int unsigned mid_at;
    settle();
    write_reg(dil3x3_pkg::REG_IMAGE_WIDTH, wv);
    write_reg(dil3x3_pkg::REG_IMAGE_HEIGHT, hv);
    mid_at = 0;
    if (mid_ok && $urandom_range(0, 4) == 0)
      mid_at = $urandom_range(1, eff_width() * eff_height());
    pix_sent = 0;
    frame_closed = 1'b0;
    while (!frame_closed) begin
      if (draining) begin
        // stray pixel during the bottom row is dropped
        if ($urandom_range(0, 19) == 0)
          send_word(dil3x3_pkg::REQ_PIXEL, rand_pix(), 1'b0, '0);
        else
          send_word(dil3x3_pkg::REQ_FLUSH, rand_pix(), 1'b0, '0);
      end else if ($urandom_range(0, 19) == 0) begin
        send_word(dil3x3_pkg::REQ_FLUSH, rand_pix(), 1'b0, '0);
      end else begin
        send_word(dil3x3_pkg::REQ_PIXEL, rand_pix(), 1'b0, '0);
        pix_sent++;
        // size change inside the frame: width never grows
        if (pix_sent == mid_at) begin
          settle();
          if ($urandom_range(0, 1) == 0)
            write_reg(dil3x3_pkg::REG_IMAGE_WIDTH,
                      dil3x3_pkg::cfg_data_t'($urandom_range(dil3x3_pkg::MIN_SIZE,
                                                             eff_width())));
          else
            write_reg(dil3x3_pkg::REG_IMAGE_HEIGHT,
                      dil3x3_pkg::cfg_data_t'($urandom_range(dil3x3_pkg::MIN_SIZE, 10)));
        end
      end
    end
  endtask

  // Receiver: random stalls plus the long hold-off
  always @(negedge clk) begin
    pix_out_bus.ready <= !long_hold && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Long hold-off so the block fills and stalls its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold = 1'b0;
  end

  // Compare each output word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && pix_out_bus.valid && pix_out_bus.ready) begin
      if (dilated_q.size() == 0) begin
        if (error_count < 10)
          $display("unexpected word: pixel_out=%0d frame_last=%0b",
                   pix_out_bus.pixel_out, pix_out_bus.frame_last);
        error_count++;
      end else begin
        want = dilated_q.pop_front();
        if (pix_out_bus.pixel_out !== want.pix || pix_out_bus.frame_last !== want.last) begin
          if (error_count < 10)
            $display("mismatch: pixel_out exp %0d got %0d, frame_last exp %0b got %0b",
                     want.pix, pix_out_bus.pixel_out, want.last, pix_out_bus.frame_last);
          error_count++;
        end
      end
    end
  end

  // Cycle limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned           send_pct [4];
    int unsigned           recv_pct [4];
    int unsigned           phase_start;
    dil3x3_pkg::cfg_data_t wv;
    dil3x3_pkg::cfg_data_t hv;
    dil_word_t             dir_word;

    send_pct = '{0, 73, 0, 14};
    recv_pct = '{0, 0, 73, 14};
    foreach (older_row[i]) begin
      older_row[i] = '0;
      prior_row[i] = '0;
    end
    pix_in_bus.valid    = 1'b0;
    pix_in_bus.req_type = dil3x3_pkg::REQ_PIXEL;
    pix_in_bus.pixel_in = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.reg_index   = dil3x3_pkg::REG_IMAGE_WIDTH;
    cfg_bus.wr_data     = '0;
    pix_out_bus.ready   = 1'b0;

    // 3x3 frame with out-of-range sizes, stray flush and stray pixel
    dir_tab = '{
      '{STEP_CFG,  dil3x3_pkg::REG_IMAGE_WIDTH,  13'd0,   1'b0, 8'd0, 1'b0},
      '{STEP_CFG,  dil3x3_pkg::REG_IMAGE_HEIGHT, 13'd2,   1'b0, 8'd0, 1'b0},
      '{STEP_WORD, dil3x3_pkg::REQ_FLUSH,        13'd0,   1'b0, 8'd0, 1'b0},
      '{STEP_WORD, dil3x3_pkg::REQ_PIXEL,        13'd255, 1'b0, 8'd0, 1'b0},
      '{STEP_WORD, dil3x3_pkg::REQ_PIXEL,        13'd0,   1'b0, 8'd0, 1'b0},
      '{STEP_WORD, dil3x3_pkg::REQ_PIXEL,        13'd128, 1'b0, 8'd0, 1'b0},
      '{STEP_WORD, dil3x3_pkg::REQ_PIXEL,        13'd0,   1'b1, 8'd0, 1'b0},
      '{STEP_WORD, dil3x3_pkg::REQ_PIXEL,        13'd255, 1'b1, 8'd0, 1'b0},
      '{STEP_WORD, dil3x3_pkg::REQ_PIXEL,        13'd1,   1'b1, 8'd0, 1'b0},
      '{STEP_WORD, dil3x3_pkg::REQ_PIXEL,        13'd7,   1'b1, 8'd0, 1'b0},
      '{STEP_WORD, dil3x3_pkg::REQ_PIXEL,        13'd0,   1'b0, 8'd0, 1'b0},
      '{STEP_WORD, dil3x3_pkg::REQ_PIXEL,        13'd200, 1'b1, 8'd0, 1'b0},
      '{STEP_WORD, dil3x3_pkg::REQ_PIXEL,        13'd99,  1'b0, 8'd0, 1'b0},
      '{STEP_WORD, dil3x3_pkg::REQ_FLUSH,        13'd0,   1'b1, 8'd0, 1'b0},
      '{STEP_WORD, dil3x3_pkg::REQ_FLUSH,        13'd0,   1'b1, 8'd0, 1'b0},
      '{STEP_WORD, dil3x3_pkg::REQ_FLUSH,        13'd0,   1'b1, 8'd0, 1'b1}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == STEP_CFG) begin
        settle();
        write_reg(dir_tab[i].sel, dir_tab[i].data);
      end else begin
        dir_word.pix  = dir_tab[i].exp_pix;
        dir_word.last = dir_tab[i].exp_last;
        send_word(dir_tab[i].sel, dir_tab[i].data[dil3x3_pkg::PIX_W-1:0],
                  dir_tab[i].known, dir_word);
      end
    end

    // Random frames in each idling phase
    for (int p = 0; p < 4; p++) begin
      settle();
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      if (p == 0) hold_go = 1'b1;
      phase_start = items_done;
      while (items_done - phase_start < ITEMS_PER_PHASE) begin
        wv = ($urandom_range(0, 9) == 0) ? dil3x3_pkg::cfg_data_t'($urandom_range(0, 2)) :
             ($urandom_range(0, 4) == 0) ? dil3x3_pkg::cfg_data_t'($urandom_range(11, 40)) :
             dil3x3_pkg::cfg_data_t'($urandom_range(3, 10));
        hv = ($urandom_range(0, 9) == 0) ? dil3x3_pkg::cfg_data_t'($urandom_range(0, 2)) :
             dil3x3_pkg::cfg_data_t'($urandom_range(3, 8));
        run_frame(wv, hv, 1'b1);
      end
    end

    settle();
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0 && dilated_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
